### sv/vbcm_pkg.sv
// ----------------------------------------------------------------------------
// vbcm_pkg
// Types and constants shared by the block cache manager modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vbcm_pkg;

   localparam int IDX_W = 11;
   localparam int LEN_W = 23;
   localparam int DIG_W = 64;
   localparam int OUT_W = 3;
   localparam int EVB_W = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 23;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_SIZE = 2'd0,
      CSR_FILE_BLOCKS = 2'd1,
      CSR_LAST_BYTES = 2'd2,
      CSR_CACHE_CAP = 2'd3
   } csr_index_type;

   typedef enum logic [OUT_W-1:0] {
      OC_CUR_HIT = 3'd0,
      OC_PAST_END = 3'd1,
      OC_CACHE_HIT = 3'd2,
      OC_FETCH = 3'd3,
      OC_MATCH = 3'd4,
      OC_FIRST_READ = 3'd5,
      OC_MISMATCH = 3'd6
   } outcome_type;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic dg_rd;
      logic dg_cmp;
      logic dg_wr;
      logic rm_rd;
      logic rm_rd_scan;
      logic scan_init;
      logic scan_step;
      logic evict;
      logic enter;
      logic ent_flag;
      logic cur_load;
      logic cur_valid_we;
      logic cur_valid_val;
      logic oc_we;
      outcome_type oc;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic is_dlv;
      logic b_ge_fb;
      logic cur_hit;
      logic cap_zero;
      logic rm_bit;
      logic same;
      logic zero;
      logic wlast;
      logic count_ge_cap;
      logic scan_done;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

### sv/vbcm_if.sv
// ----------------------------------------------------------------------------
// vbcm channel interfaces
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface vbcm_req_if import vbcm_pkg::*; ();
   logic valid;
   logic ready;
   logic req_type;
   logic [IDX_W-1:0] block_index;
   logic [DIG_W-1:0] digest_w0;
   logic [DIG_W-1:0] digest_w1;
   logic [DIG_W-1:0] digest_w2;
   logic [DIG_W-1:0] digest_w3;
   modport source (output valid, req_type, block_index, digest_w0, digest_w1, digest_w2,
                   digest_w3, input ready);
   modport sink (input valid, req_type, block_index, digest_w0, digest_w1, digest_w2,
                 digest_w3, output ready);
endinterface

interface vbcm_rsp_if import vbcm_pkg::*; ();
   logic valid;
   logic ready;
   logic [OUT_W-1:0] outcome;
   logic [LEN_W-1:0] fetch_length;
   logic entered_cache;
   logic evict_valid;
   logic [EVB_W-1:0] evicted_block;
   modport source (output valid, outcome, fetch_length, entered_cache, evict_valid,
                   evicted_block, input ready);
   modport sink (input valid, outcome, fetch_length, entered_cache, evict_valid,
                 evicted_block, output ready);
endinterface

`default_nettype wire

### sv/vbcm_ctrl.sv
// ----------------------------------------------------------------------------
// vbcm_ctrl
// Sequencer that steps the datapath through lookups, digest checks and scans.
// ----------------------------------------------------------------------------
`default_nettype none

module vbcm_ctrl import vbcm_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_fire,
   output logic            req_ready,
   input  wire status_type st,
   output cmd_type         cmd
);

   typedef enum logic [12:0] {
      S_CLEAR = 13'b0000000000001,
      S_IDLE  = 13'b0000000000010,
      S_DISP  = 13'b0000000000100,
      S_RCHK  = 13'b0000000001000,
      S_DRD   = 13'b0000000010000,
      S_DCK   = 13'b0000000100000,
      S_DEC   = 13'b0000001000000,
      S_DWR   = 13'b0000010000000,
      S_MCK   = 13'b0000100000000,
      S_SRD   = 13'b0001000000000,
      S_SCK   = 13'b0010000000000,
      S_ENTER = 13'b0100000000000,
      S_FIN   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.oc = OC_CUR_HIT;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_FIN;
            cmd.oc_we = 1'b1;
            if (!st.is_dlv) begin
               if (st.cur_hit) begin
                  cmd.oc = OC_CUR_HIT;
               end else if (st.b_ge_fb) begin
                  cmd.oc = OC_PAST_END;
                  cmd.cur_load = 1'b1;
                  cmd.cur_valid_we = 1'b1;
                  cmd.cur_valid_val = 1'b1;
               end else if (st.cap_zero) begin
                  cmd.oc = OC_FETCH;
               end else begin
                  cmd.oc_we = 1'b0;
                  cmd.rm_rd = 1'b1;
                  state_in = S_RCHK;
               end
            end else if (st.b_ge_fb) begin
               cmd.oc = OC_MISMATCH;
               cmd.cur_valid_we = 1'b1;
            end else begin
               cmd.oc_we = 1'b0;
               state_in = S_DRD;
            end
         end
         S_RCHK: begin
            cmd.oc_we = 1'b1;
            state_in = S_FIN;
            if (st.rm_bit) begin
               cmd.oc = OC_CACHE_HIT;
               cmd.cur_load = 1'b1;
               cmd.cur_valid_we = 1'b1;
               cmd.cur_valid_val = 1'b1;
            end else begin
               cmd.oc = OC_FETCH;
            end
         end
         S_DRD: begin
            cmd.dg_rd = 1'b1;
            state_in = S_DCK;
         end
         S_DCK: begin
            cmd.dg_cmp = 1'b1;
            state_in = st.wlast ? S_DEC : S_DRD;
         end
         S_DEC: begin
            cmd.cur_load = 1'b1;
            cmd.cur_valid_we = 1'b1;
            cmd.cur_valid_val = 1'b1;
            if (st.same) begin
               cmd.oc_we = 1'b1;
               cmd.oc = OC_MATCH;
               state_in = S_FIN;
            end else if (!st.zero) begin
               cmd.oc_we = 1'b1;
               cmd.oc = OC_MISMATCH;
               cmd.cur_valid_val = 1'b0;
               state_in = S_FIN;
            end else begin
               state_in = S_DWR;
            end
         end
         S_DWR: begin
            cmd.dg_wr = 1'b1;
            if (st.wlast) begin
               if (st.cap_zero) begin
                  cmd.oc_we = 1'b1;
                  cmd.oc = OC_FIRST_READ;
                  state_in = S_FIN;
               end else begin
                  cmd.rm_rd = 1'b1;
                  state_in = S_MCK;
               end
            end
         end
         S_MCK: begin
            if (st.rm_bit) begin
               cmd.ent_flag = 1'b1;
               cmd.oc_we = 1'b1;
               cmd.oc = OC_FIRST_READ;
               state_in = S_FIN;
            end else if (st.count_ge_cap) begin
               cmd.scan_init = 1'b1;
               state_in = S_SRD;
            end else begin
               state_in = S_ENTER;
            end
         end
         S_SRD: begin
            if (st.scan_done) begin
               state_in = S_ENTER;
            end else begin
               cmd.rm_rd = 1'b1;
               cmd.rm_rd_scan = 1'b1;
               state_in = S_SCK;
            end
         end
         S_SCK: begin
            if (st.rm_bit) begin
               cmd.evict = 1'b1;
               state_in = S_ENTER;
            end else begin
               cmd.scan_step = 1'b1;
               state_in = S_SRD;
            end
         end
         S_ENTER: begin
            cmd.enter = !st.count_ge_cap;
            cmd.oc_we = 1'b1;
            cmd.oc = OC_FIRST_READ;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (st.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/vbcm_dp.sv
// ----------------------------------------------------------------------------
// vbcm_dp
// Configuration, digest store, residency map, scan counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vbcm_dp import vbcm_pkg::*; #(
   parameter int MAX_BLOCKS = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata,
   vbcm_req_if.sink                  req,
   vbcm_rsp_if.source                rsp,
   input  wire cmd_type              cmd,
   output status_type                st
);

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int DW = IW + 2;
   localparam bit CLIP = MAX_BLOCKS < 2048;

   logic [LEN_W-1:0] block_size_ff, last_bytes_ff;
   logic [IDX_W-1:0] file_blocks_ff, cache_cap_ff;
   logic [IDX_W-1:0] fb;

   logic             type_ff;
   logic [IDX_W-1:0] b_ff;
   logic [DIG_W-1:0] dig_ff [4];
   logic [1:0]       wcnt_ff;
   logic             same_ff, zero_ff;
   logic [IDX_W-1:0] cur_block_ff;
   logic             cur_valid_ff;
   logic [IDX_W-1:0] count_ff, n_ff, left_ff;
   logic [DW-1:0]    clr_ff;
   logic             ent_ff, ev_ff;
   logic [EVB_W-1:0] evb_ff;
   outcome_type      oc_ff;

   logic [DIG_W-1:0] dg_mem [4*MAX_BLOCKS];
   logic [DIG_W-1:0] dg_q_ff;
   logic             rm_mem [MAX_BLOCKS];
   logic             rm_q_ff;

   logic             rsp_valid_ff;
   logic [OUT_W-1:0] rsp_oc_ff;
   logic [LEN_W-1:0] rsp_len_ff;
   logic             rsp_ent_ff, rsp_ev_ff;
   logic [EVB_W-1:0] rsp_evb_ff;
   logic [LEN_W-1:0] flen;

   logic [DW-1:0]    dg_addr;
   logic             rm_we, rm_wdata;
   logic [IW-1:0]    rm_waddr, rm_raddr;

   assign fb = (CLIP && (32'(file_blocks_ff) > MAX_BLOCKS)) ? IDX_W'(MAX_BLOCKS)
                                                             : file_blocks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= LEN_W'(4096);
         file_blocks_ff <= '0;
         last_bytes_ff <= LEN_W'(4096);
         cache_cap_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_SIZE: block_size_ff <= csr_wdata;
            CSR_FILE_BLOCKS: file_blocks_ff <= csr_wdata[IDX_W-1:0];
            CSR_LAST_BYTES: last_bytes_ff <= csr_wdata;
            CSR_CACHE_CAP: cache_cap_ff <= csr_wdata[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req.req_type;
         b_ff <= req.block_index;
         dig_ff[0] <= req.digest_w0;
         dig_ff[1] <= req.digest_w1;
         dig_ff[2] <= req.digest_w2;
         dig_ff[3] <= req.digest_w3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         cur_block_ff <= '0;
         cur_valid_ff <= 1'b0;
         count_ff <= '0;
         wcnt_ff <= '0;
         same_ff <= 1'b1;
         zero_ff <= 1'b1;
         ent_ff <= 1'b0;
         ev_ff <= 1'b0;
         evb_ff <= '0;
         n_ff <= '0;
         left_ff <= '0;
         oc_ff <= OC_CUR_HIT;
      end else begin
         if (cmd.clr_step) clr_ff <= clr_ff + DW'(1);
         if (cmd.load) begin
            wcnt_ff <= '0;
            same_ff <= 1'b1;
            zero_ff <= 1'b1;
            ent_ff <= 1'b0;
            ev_ff <= 1'b0;
            evb_ff <= '0;
         end
         if (cmd.dg_cmp) begin
            if (dg_q_ff != dig_ff[wcnt_ff]) same_ff <= 1'b0;
            if (dg_q_ff != '0) zero_ff <= 1'b0;
         end
         if (cmd.dg_cmp || cmd.dg_wr) wcnt_ff <= wcnt_ff + 2'd1;
         if (cmd.cur_load) cur_block_ff <= b_ff;
         if (cmd.cur_valid_we) cur_valid_ff <= cmd.cur_valid_val;
         if (cmd.scan_init) begin
            n_ff <= (b_ff == '0) ? fb - IDX_W'(1) : b_ff - IDX_W'(1);
            left_ff <= fb - IDX_W'(1);
         end
         if (cmd.scan_step) begin
            n_ff <= (n_ff == '0) ? fb - IDX_W'(1) : n_ff - IDX_W'(1);
            left_ff <= left_ff - IDX_W'(1);
         end
         if (cmd.evict) begin
            count_ff <= count_ff - IDX_W'(1);
            ev_ff <= 1'b1;
            evb_ff <= n_ff[EVB_W-1:0];
         end
         if (cmd.enter) begin
            count_ff <= count_ff + IDX_W'(1);
            ent_ff <= 1'b1;
         end
         if (cmd.ent_flag) ent_ff <= 1'b1;
         if (cmd.oc_we) oc_ff <= cmd.oc;
      end
   end

   assign dg_addr = cmd.clr_step ? clr_ff : {IW'(b_ff), wcnt_ff};

   always_ff @(posedge clock) begin
      if (cmd.clr_step || cmd.dg_wr) begin
         dg_mem[dg_addr] <= cmd.clr_step ? '0 : dig_ff[wcnt_ff];
      end
      if (cmd.dg_rd) dg_q_ff <= dg_mem[dg_addr];
   end

   always_comb begin
      rm_we = cmd.clr_step || cmd.evict || cmd.enter;
      rm_wdata = cmd.enter;
      rm_waddr = IW'(b_ff);
      if (cmd.clr_step) rm_waddr = clr_ff[DW-1:2];
      else if (cmd.evict) rm_waddr = IW'(n_ff);
      rm_raddr = cmd.rm_rd_scan ? IW'(n_ff) : IW'(b_ff);
   end

   always_ff @(posedge clock) begin
      if (rm_we) rm_mem[rm_waddr] <= rm_wdata;
      if (cmd.rm_rd) rm_q_ff <= rm_mem[rm_raddr];
   end

   always_comb begin
      flen = '0;
      if (oc_ff == OC_FETCH) begin
         if (b_ff == fb - IDX_W'(1)) begin
            flen = (last_bytes_ff < block_size_ff) ? last_bytes_ff : block_size_ff;
         end else begin
            flen = block_size_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_oc_ff <= oc_ff;
         rsp_len_ff <= flen;
         rsp_ent_ff <= ent_ff;
         rsp_ev_ff <= ev_ff;
         rsp_evb_ff <= evb_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.outcome = rsp_oc_ff;
   assign rsp.fetch_length = rsp_len_ff;
   assign rsp.entered_cache = rsp_ent_ff;
   assign rsp.evict_valid = rsp_ev_ff;
   assign rsp.evicted_block = rsp_evb_ff;

   always_comb begin
      st.clr_done = (clr_ff == DW'(4*MAX_BLOCKS-1));
      st.is_dlv = type_ff;
      st.b_ge_fb = (b_ff >= fb);
      st.cur_hit = cur_valid_ff && (b_ff == cur_block_ff);
      st.cap_zero = (cache_cap_ff == '0);
      st.rm_bit = rm_q_ff;
      st.same = same_ff;
      st.zero = zero_ff;
      st.wlast = (wcnt_ff == 2'd3);
      st.count_ge_cap = (count_ff >= cache_cap_ff);
      st.scan_done = (left_ff == '0);
      st.rsp_free = !rsp_valid_ff || rsp.ready;
   end

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp.ready))
      else $error("Response overwritten while still pending.");

   a_write_only_unread: assert property (@(posedge clock) disable iff (reset)
      cmd.dg_wr |-> (zero_ff && !same_ff))
      else $error("Digest written for a block that was already read.");

   a_evict_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |-> (count_ff != '0))
      else $error("Eviction with no resident blocks counted.");

endmodule

`default_nettype wire

### sv/verified_block_cache_manager_unit.sv
// ----------------------------------------------------------------------------
// verified_block_cache_manager_unit
// Block lookup and first-read digest bookkeeping with a residency cache.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// req      in   req_type, block_index, digest_w0..digest_w3
// rsp      out  outcome, fetch_length, entered_cache, evict_valid, evicted_block
// csr      in   csr_we, csr_index, csr_wdata
//
// A lookup goes from dispatch to finish, reading the residency map for a miss inside
// the file when the cache is in use; a delivery outside the file goes straight to
// finish. Any other delivery reads and compares the digest words, writes them for an
// unread block, and may scan the residency map when a full cache looks for a victim.
// The delivery time is set by the single port of the digest store, one word per access.
// After reset no word is accepted until the digest store and residency map are clear.
// A new word is accepted while a finished response still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module verified_block_cache_manager_unit import vbcm_pkg::*; #(
   parameter int MAX_BLOCKS = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata,
   vbcm_req_if.sink                  req_chan,
   vbcm_rsp_if.source                rsp_chan
);

   cmd_type    cmd;
   status_type st;
   logic       ready;

   assign req_chan.ready = ready;

   vbcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_chan.valid && ready),
      .req_ready (ready),
      .st        (st),
      .cmd       (cmd)
   );

   vbcm_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .cmd       (cmd),
      .st        (st)
   );

endmodule

`default_nettype wire

### tb/vbcm_result_checker.sv
// ----------------------------------------------------------------------------
// vbcm_result_checker
// Watches the configuration port and both channels of the block cache
// manager, predicts the response to every accepted request word from its
// own copy of the registers, residency map and digest store, and compares
// each accepted response word with the oldest prediction.
// ----------------------------------------------------------------------------
module vbcm_result_checker import vbcm_pkg::*; #(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   vbcm_req_if                  req_mon,
   vbcm_rsp_if                  rsp_mon,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      outcome_type      oc;
      logic [LEN_W-1:0] len;
      logic             entered;
      logic             ev_valid;
      logic [EVB_W-1:0] ev_block;
   } lookup_result_t;

   logic [LEN_W-1:0] blk_size;
   logic [IDX_W-1:0] file_blks;
   logic [LEN_W-1:0] last_bytes;
   logic [IDX_W-1:0] cache_cap;

   logic [IDX_W-1:0] cur_blk;
   logic             cur_valid;
   logic             resident [0:MAX_BLOCKS-1];
   int               resident_cnt;
   logic [DIG_W-1:0] digests [0:4*MAX_BLOCKS-1];

   lookup_result_t   expected_q[$];

   function automatic lookup_result_t predict_lookup(logic is_dlv, logic [IDX_W-1:0] b,
                                                    logic [4*DIG_W-1:0] dig);
      lookup_result_t r;
      int fb;
      int n;
      logic same;
      logic zero;
      r = '0;
      r.oc = OC_CUR_HIT;
      fb = (file_blks > MAX_BLOCKS) ? MAX_BLOCKS : int'(file_blks);
      if (!is_dlv) begin
         if (cur_valid && b == cur_blk) begin
            r.oc = OC_CUR_HIT;
         end else if (b >= fb) begin
            r.oc = OC_PAST_END;
            cur_blk = b;
            cur_valid = 1'b1;
         end else if (cache_cap != 0 && resident[b]) begin
            r.oc = OC_CACHE_HIT;
            cur_blk = b;
            cur_valid = 1'b1;
         end else begin
            r.oc = OC_FETCH;
            if (b == fb - 1)
               r.len = (last_bytes < blk_size) ? last_bytes : blk_size;
            else
               r.len = blk_size;
         end
      end else if (b >= fb) begin
         r.oc = OC_MISMATCH;
         cur_valid = 1'b0;
      end else begin
         same = 1'b1;
         zero = 1'b1;
         for (int w = 0; w < 4; w++) begin
            if (digests[b*4+w] != dig[(3-w)*DIG_W +: DIG_W]) same = 1'b0;
            if (digests[b*4+w] != '0) zero = 1'b0;
         end
         cur_blk = b;
         cur_valid = 1'b1;
         if (same) begin
            r.oc = OC_MATCH;
         end else if (!zero) begin
            r.oc = OC_MISMATCH;
            cur_valid = 1'b0;
         end else begin
            r.oc = OC_FIRST_READ;
            for (int w = 0; w < 4; w++) digests[b*4+w] = dig[(3-w)*DIG_W +: DIG_W];
            if (cache_cap != 0) begin
               if (resident[b]) begin
                  r.entered = 1'b1;
               end else begin
                  if (resident_cnt >= cache_cap) begin
                     for (int k = 1; k < fb; k++) begin
                        n = (int'(b) + fb - k) % fb;
                        if (resident[n]) begin
                           resident[n] = 1'b0;
                           resident_cnt--;
                           r.ev_valid = 1'b1;
                           r.ev_block = n[EVB_W-1:0];
                           break;
                        end
                     end
                  end
                  if (resident_cnt < cache_cap) begin
                     resident[b] = 1'b1;
                     resident_cnt++;
                     r.entered = 1'b1;
                  end
               end
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_result_t exp_r;
      if (reset) begin
         blk_size = 23'd4096;
         file_blks = '0;
         last_bytes = 23'd4096;
         cache_cap = '0;
         cur_blk = '0;
         cur_valid = 1'b0;
         resident_cnt = 0;
         for (int i = 0; i < MAX_BLOCKS; i++) resident[i] = 1'b0;
         for (int i = 0; i < 4*MAX_BLOCKS; i++) digests[i] = '0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_BLOCK_SIZE: blk_size = csr_wdata;
               CSR_FILE_BLOCKS: file_blks = csr_wdata[IDX_W-1:0];
               CSR_LAST_BYTES: last_bytes = csr_wdata;
               CSR_CACHE_CAP: cache_cap = csr_wdata[IDX_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               $error("response word with no prediction waiting");
               fail_count++;
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_mon.outcome !== exp_r.oc) begin
                  $error("outcome: expected %0d, actual %0d", exp_r.oc, rsp_mon.outcome);
                  fail_count++;
               end
               if (rsp_mon.fetch_length !== exp_r.len) begin
                  $error("fetch_length: expected %0d, actual %0d", exp_r.len,
                         rsp_mon.fetch_length);
                  fail_count++;
               end
               if (rsp_mon.entered_cache !== exp_r.entered) begin
                  $error("entered_cache: expected %0d, actual %0d", exp_r.entered,
                         rsp_mon.entered_cache);
                  fail_count++;
               end
               if (rsp_mon.evict_valid !== exp_r.ev_valid) begin
                  $error("evict_valid: expected %0d, actual %0d", exp_r.ev_valid,
                         rsp_mon.evict_valid);
                  fail_count++;
               end
               if (rsp_mon.evicted_block !== exp_r.ev_block) begin
                  $error("evicted_block: expected %0d, actual %0d", exp_r.ev_block,
                         rsp_mon.evicted_block);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_q.push_back(predict_lookup(req_mon.req_type, req_mon.block_index,
                                 {req_mon.digest_w0, req_mon.digest_w1,
                                  req_mon.digest_w2, req_mon.digest_w3}));
         end
      end
      pending = expected_q.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end

endmodule

### tb/tb_verified_block_cache_manager_unit.sv
// ----------------------------------------------------------------------------
// tb_verified_block_cache_manager_unit
// Drives directed and random lookup and digest words through the block
// cache manager under several register settings, with bursty input, a
// stalling output, one long output hold and full drains, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_verified_block_cache_manager_unit;
   import vbcm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BLOCKS = 1024;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;
   int                   fail_count;
   int                   pending;

   vbcm_req_if req_chan ();
   vbcm_rsp_if rsp_chan ();

   verified_block_cache_manager_unit #(.MAX_BLOCKS(MAX_BLOCKS)) u_top (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   vbcm_result_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_checker (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .fail_count(fail_count), .pending(pending)
   );

   logic [4*DIG_W-1:0] host_digest [0:MAX_BLOCKS-1];
   int  words_sent;
   int  burst_left;
   int  phase_blocks;
   bit  long_hold_done;
   bit  drain_done;

   always #1 clock = ~clock;

   initial begin
      #20ms;
      $display("tb_verified_block_cache_manager_unit NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      int stretch;
      int mode;
      if (!long_hold_done && words_sent > 400) begin
         long_hold_done = 1'b1;
         rsp_chan.ready <= 1'b0;
         repeat (400) @(posedge clock);
      end else begin
         stretch = $urandom_range(5, 60);
         mode = $urandom_range(0, 2);
         repeat (stretch) begin
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic send_word(logic is_dlv, logic [IDX_W-1:0] b, logic [4*DIG_W-1:0] dig);
      req_chan.valid <= 1'b1;
      req_chan.req_type <= is_dlv;
      req_chan.block_index <= b;
      {req_chan.digest_w0, req_chan.digest_w1, req_chan.digest_w2, req_chan.digest_w3} <= dig;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 20);
         if ($urandom_range(0, 3) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_regs(int bs, int fb, int lb, int cap);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_BLOCK_SIZE;
      csr_wdata <= bs[CSR_DAT_W-1:0];
      @(posedge clock);
      csr_index <= CSR_FILE_BLOCKS;
      csr_wdata <= fb[CSR_DAT_W-1:0];
      @(posedge clock);
      csr_index <= CSR_LAST_BYTES;
      csr_wdata <= lb[CSR_DAT_W-1:0];
      @(posedge clock);
      csr_index <= CSR_CACHE_CAP;
      csr_wdata <= cap[CSR_DAT_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      phase_blocks = (fb > MAX_BLOCKS) ? MAX_BLOCKS : fb;
   endtask

   function automatic logic [4*DIG_W-1:0] rand_digest();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [4*DIG_W-1:0] pick_digest(int b);
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return host_digest[b % MAX_BLOCKS];
      if (r < 93) return rand_digest();
      return '0;
   endfunction

   task automatic random_words(int count);
      int r;
      int b;
      int last_b;
      last_b = 0;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (!drain_done && words_sent > 600) begin
            drain_done = 1'b1;
            drain();
         end
         b = (phase_blocks > 0) ? $urandom_range(0, phase_blocks - 1) : 0;
         if (phase_blocks > 0 && r < 50) begin
            send_word(1'b0, IDX_W'(b), rand_digest());
            send_word(1'b1, IDX_W'(b), pick_digest(b));
            last_b = b;
         end else if (phase_blocks > 0 && r < 65) begin
            send_word(1'b0, IDX_W'(b), rand_digest());
         end else if (phase_blocks > 0 && r < 78) begin
            send_word(1'b1, IDX_W'(last_b), pick_digest(last_b));
         end else begin
            b = $urandom_range(0, 2047);
            send_word(1'($urandom_range(0, 1)), IDX_W'(b), ($urandom_range(0, 1) != 0) ?
                      rand_digest() : pick_digest(b));
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_BLOCK_SIZE;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.req_type = 1'b0;
      req_chan.block_index = '0;
      req_chan.digest_w0 = '0;
      req_chan.digest_w1 = '0;
      req_chan.digest_w2 = '0;
      req_chan.digest_w3 = '0;
      rsp_chan.ready = 1'b0;
      words_sent = 0;
      burst_left = 0;
      phase_blocks = 0;
      long_hold_done = 1'b0;
      drain_done = 1'b0;
      for (int i = 0; i < MAX_BLOCKS; i++) host_digest[i] = rand_digest();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With an empty file every lookup is past the end and every digest mismatches.
      send_word(1'b0, 11'd0, '0);
      send_word(1'b1, 11'd5, rand_digest());
      send_word(1'b0, 11'd2047, '0);

      write_regs(1024, 8, 23'h7FFFFF, 2);
      send_word(1'b0, 11'd7, '0);
      send_word(1'b0, 11'd3, '0);
      send_word(1'b1, 11'd3, host_digest[3]);
      send_word(1'b0, 11'd3, '0);
      send_word(1'b1, 11'd3, host_digest[3]);
      send_word(1'b1, 11'd3, rand_digest());
      send_word(1'b1, 11'd5, '0);
      send_word(1'b1, 11'd5, host_digest[5]);
      send_word(1'b0, 11'd3, '0);
      send_word(1'b1, 11'd6, host_digest[6]);
      send_word(1'b1, 11'd0, host_digest[0]);
      send_word(1'b1, 11'd9, host_digest[9]);

      // Oversized file, zero block size, single-entry cache.
      write_regs(0, 2047, 1, 1);
      send_word(1'b0, 11'd1023, '0);
      send_word(1'b0, 11'd100, '0);
      send_word(1'b1, 11'd500, host_digest[500]);
      send_word(1'b0, 11'd1024, '0);

      write_regs(23'h400000, 2, 23'h400000, 1);
      send_word(1'b1, 11'd1, host_digest[1]);
      send_word(1'b0, 11'd1, '0);
      send_word(1'b0, 11'd0, '0);

      write_regs(1024, 16, 1, 4);
      random_words(90);
      write_regs(23'h7FFFFF, 64, 23'h7FFFFF, 0);
      random_words(90);
      write_regs(4096, 32, 100, 8);
      random_words(100);
      write_regs(23'h7FFFFF, 1024, 4096, 1024);
      random_words(90);
      write_regs(2048, 2047, 300, 1);
      random_words(70);
      write_regs(1024, 2, 1024, 1);
      random_words(80);
      write_regs(65536, 24, 70000, 3);
      random_words(80);
      write_regs(4096, 0, 4096, 0);
      random_words(30);

      drain();
      if (fail_count == 0) begin
         $display("tb_verified_block_cache_manager_unit OK");
      end else begin
         $display("tb_verified_block_cache_manager_unit NOT OK");
      end
      $finish;
   end

endmodule

### filelist.f
sv/vbcm_pkg.sv
sv/vbcm_if.sv
sv/vbcm_ctrl.sv
sv/vbcm_dp.sv
sv/verified_block_cache_manager_unit.sv
tb/vbcm_result_checker.sv
tb/tb_verified_block_cache_manager_unit.sv
